// ===== design/urd_pkg.sv =====
// Shared types and constants for the ultrasonic ranging depth controller.
`timescale 1ns / 1ps

package urd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   localparam int PIPE_W      = 22;
   localparam int SPEED_W     = 12;
   localparam int TRIG_W      = 8;
   localparam int TIMEOUT_W   = 16;
   localparam int PAUSE_W     = 20;

   localparam int WID_W       = 16;
   localparam int DIST_W      = 21;
   localparam int DEPTH_W     = 23;
   localparam int PROD_W      = WID_W + SPEED_W;
   localparam int DIST_SHIFT  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIPE_LENGTH   = 3'd0,
      CSR_SPEED         = 3'd1,
      CSR_TRIG_LOW      = 3'd2,
      CSR_TRIG_HIGH     = 3'd3,
      CSR_ECHO_TIMEOUT  = 3'd4,
      CSR_ERROR_PAUSE   = 3'd5,
      CSR_MEASURE_PAUSE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_TRIG_LOW   = 3'd0,
      PH_TRIG_HIGH  = 3'd1,
      PH_WAIT_RISE  = 3'd2,
      PH_WAIT_FALL  = 3'd3,
      PH_PAUSE_ERR  = 3'd4,
      PH_PAUSE_MEAS = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_MEASURE      = 2'd1,
      EV_RISE_TIMEOUT = 2'd2,
      EV_FALL_TIMEOUT = 2'd3
   } event_code_type;

   typedef struct packed {
      logic [PIPE_W-1:0]    pipe_length_q10;
      logic [SPEED_W-1:0]   speed_q16;
      logic [TRIG_W-1:0]    trig_low_us;
      logic [TRIG_W-1:0]    trig_high_us;
      logic [TIMEOUT_W-1:0] echo_timeout_us;
      logic [PAUSE_W-1:0]   error_pause_us;
      logic [PAUSE_W-1:0]   measure_pause_us;
   } cfg_type;

   typedef struct packed {
      logic           trigger_level;
      event_code_type event_code;
      logic [WID_W-1:0] echo_width_us;
   } seq_out_type;

endpackage

// ===== design/ultrasonic_range_depth_controller_unit.sv =====
// Top level: tick input register, ranging sequencer and result register.
`timescale 1ns / 1ps

// Flow: an accepted tick beat waits in the input stage register until the result
// register has room, and then the sequencer's beat is captured in the result register.
// Throughput: one tick beat per cycle unless stalled; the sequencer updates its phase, timer
// and width counter once per beat, and the result register holds one beat under stall.
// Reset (synchronous, active high) clears both stages, puts the sequencer in the
// trigger-low phase with cleared counters and loads the default register values.
module ultrasonic_range_depth_controller_unit #(
   parameter int TIMER_BITS = 20,
   parameter int WIDTH_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [urd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [urd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_echo_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_trigger_level,
   output logic [1:0]                         rsp_event_code,
   output logic [urd_pkg::WID_W-1:0]          rsp_echo_width_us,
   output logic [urd_pkg::DIST_W-1:0]         rsp_distance_q10,
   output logic signed [urd_pkg::DEPTH_W-1:0] rsp_depth_q10
);
   import urd_pkg::*;

   cfg_type      cfg;
   seq_out_type  seq_out;

   logic s1_valid_ff, s1_valid_in;
   logic s1_echo_ff;
   logic out_free;
   logic step;
   logic req_accept;

   logic [DIST_W-1:0]         dist_c;
   logic signed [DEPTH_W-1:0] depth_c;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      trig_ff;
   event_code_type            event_ff;
   logic [WID_W-1:0]          width_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic signed [DEPTH_W-1:0] depth_ff;

   urd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   urd_seq #(
      .TIMER_BITS (TIMER_BITS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .echo_level (s1_echo_ff),
      .cfg        (cfg),
      .seq_out    (seq_out)
   );

   urd_calc u_calc (
      .measure         (seq_out.event_code == EV_MEASURE),
      .echo_width_us   (seq_out.echo_width_us),
      .speed_q16       (cfg.speed_q16),
      .pipe_length_q10 (cfg.pipe_length_q10),
      .distance_q10    (dist_c),
      .depth_q10       (depth_c)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_echo_ff <= req_echo_level;
      end
      if (step) begin
         trig_ff  <= seq_out.trigger_level;
         event_ff <= seq_out.event_code;
         width_ff <= seq_out.echo_width_us;
         dist_ff  <= dist_c;
         depth_ff <= depth_c;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = trig_ff;
   assign rsp_event_code    = event_ff;
   assign rsp_echo_width_us = width_ff;
   assign rsp_distance_q10  = dist_ff;
   assign rsp_depth_q10     = depth_ff;

`ifndef NO_ASSERTIONS
   // Only a measurement beat carries width, distance and depth.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff != EV_MEASURE) |->
         (width_ff == '0 && dist_ff == '0 && depth_ff == '0))
      else $error("result fields nonzero outside a measurement");

   // A measurement ends while waiting for the echo fall, with the trigger low.
   a_meas_trig_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff == EV_MEASURE) |-> !trig_ff)
      else $error("measurement reported with trigger high");

   // An accepted tick is held in the input stage until the sequencer takes it.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted tick lost from the input stage");

   // The sequencer advances only when the result register can take its beat.
   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("sequencer beat not captured in the result register");
`endif

endmodule

// ===== design/urd_csr.sv =====
// Configuration register file, written one register per beat.
`timescale 1ns / 1ps

module urd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [urd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [urd_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output urd_pkg::cfg_type                  cfg
);
   import urd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIPE_LENGTH:   cfg_in.pipe_length_q10  = csr_write_data[PIPE_W-1:0];
            CSR_SPEED:         cfg_in.speed_q16        = csr_write_data[SPEED_W-1:0];
            CSR_TRIG_LOW:      cfg_in.trig_low_us      = csr_write_data[TRIG_W-1:0];
            CSR_TRIG_HIGH:     cfg_in.trig_high_us     = csr_write_data[TRIG_W-1:0];
            CSR_ECHO_TIMEOUT:  cfg_in.echo_timeout_us  = csr_write_data[TIMEOUT_W-1:0];
            CSR_ERROR_PAUSE:   cfg_in.error_pause_us   = csr_write_data[PAUSE_W-1:0];
            CSR_MEASURE_PAUSE: cfg_in.measure_pause_us = csr_write_data[PAUSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pipe_length_q10  <= PIPE_W'(49152);
         cfg_ff.speed_q16        <= SPEED_W'(885);
         cfg_ff.trig_low_us      <= TRIG_W'(2);
         cfg_ff.trig_high_us     <= TRIG_W'(10);
         cfg_ff.echo_timeout_us  <= TIMEOUT_W'(50000);
         cfg_ff.error_pause_us   <= PAUSE_W'(100000);
         cfg_ff.measure_pause_us <= PAUSE_W'(500000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/urd_seq.sv =====
// Trigger and echo timing state machine, advanced once per tick beat.
`timescale 1ns / 1ps

module urd_seq #(
   parameter int TIMER_BITS = 20,
   parameter int WIDTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  echo_level,
   input  urd_pkg::cfg_type      cfg,
   output urd_pkg::seq_out_type  seq_out
);
   import urd_pkg::*;

   // Compare width covers both the timer and the widest length register.
   localparam int CW = (TIMER_BITS > PAUSE_W) ? TIMER_BITS : PAUSE_W;
   localparam int MW = (WIDTH_BITS > WID_W) ? WIDTH_BITS : WID_W;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   logic [WIDTH_BITS-1:0]   width_ff, width_in;

   logic [TIMER_BITS-1:0]   timer_inc;
   logic [PAUSE_W-1:0]      len_sel;
   logic                    timed_done;
   logic                    timeout_hit;
   logic [MW-1:0]           width_wide;

   assign timer_inc = (timer_ff == TIMER_MAX) ? TIMER_MAX : timer_ff + TIMER_BITS'(1);

   always_comb begin
      case (phase_ff)
         PH_TRIG_HIGH:  len_sel = PAUSE_W'(cfg.trig_high_us);
         PH_PAUSE_ERR:  len_sel = cfg.error_pause_us;
         PH_PAUSE_MEAS: len_sel = cfg.measure_pause_us;
         default:       len_sel = PAUSE_W'(cfg.trig_low_us);
      endcase
   end

   // A zero length still lasts one tick, and a length past the timer's
   // range ends once the timer saturates.
   assign timed_done = (CW'(timer_inc) >= CW'(len_sel)) || (timer_inc == TIMER_MAX);
   assign timeout_hit = (CW'(timer_ff) >= CW'(cfg.echo_timeout_us)) ||
                        (timer_ff == TIMER_MAX);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      width_in = width_ff;
      case (phase_ff)
         PH_TRIG_HIGH: begin
            timer_in = timer_inc;
            if (timed_done) begin
               phase_in = PH_WAIT_RISE;
               timer_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               phase_in = PH_WAIT_FALL;
               timer_in = '0;
               width_in = '0;
            end else if (timeout_hit) begin
               phase_in = PH_PAUSE_ERR;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_WAIT_FALL: begin
            if (!echo_level) begin
               phase_in = PH_PAUSE_MEAS;
               timer_in = '0;
            end else if (timeout_hit) begin
               phase_in = PH_PAUSE_ERR;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
               if (width_ff != WIDTH_MAX) begin
                  width_in = width_ff + WIDTH_BITS'(1);
               end
            end
         end
         PH_PAUSE_ERR, PH_PAUSE_MEAS: begin
            timer_in = timer_inc;
            if (timed_done) begin
               phase_in = PH_TRIG_LOW;
               timer_in = '0;
            end
         end
         default: begin
            phase_in = PH_TRIG_LOW;
            timer_in = timer_inc;
            if (timed_done) begin
               phase_in = PH_TRIG_HIGH;
               timer_in = '0;
            end
         end
      endcase
   end

   assign width_wide = MW'(width_ff);

   // Outputs
   always_comb begin
      seq_out.trigger_level = 1'b0;
      seq_out.event_code    = EV_NONE;
      seq_out.echo_width_us = '0;
      case (phase_ff)
         PH_TRIG_HIGH: begin
            seq_out.trigger_level = 1'b1;
         end
         PH_WAIT_RISE: begin
            if (!echo_level && timeout_hit) begin
               seq_out.event_code = EV_RISE_TIMEOUT;
            end
         end
         PH_WAIT_FALL: begin
            if (!echo_level) begin
               seq_out.event_code    = EV_MEASURE;
               seq_out.echo_width_us = (width_wide > MW'({WID_W{1'b1}})) ?
                                       {WID_W{1'b1}} : width_wide[WID_W-1:0];
            end else if (timeout_hit) begin
               seq_out.event_code = EV_FALL_TIMEOUT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG_LOW;
         timer_ff <= '0;
         width_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         width_ff <= width_in;
      end
   end

endmodule

// ===== design/urd_calc.sv =====
// Distance and depth arithmetic for a finished echo measurement.
`timescale 1ns / 1ps

module urd_calc (
   input  logic                               measure,
   input  logic [urd_pkg::WID_W-1:0]          echo_width_us,
   input  logic [urd_pkg::SPEED_W-1:0]        speed_q16,
   input  logic [urd_pkg::PIPE_W-1:0]         pipe_length_q10,
   output logic [urd_pkg::DIST_W-1:0]         distance_q10,
   output logic signed [urd_pkg::DEPTH_W-1:0] depth_q10
);
   import urd_pkg::*;

   logic [PROD_W-1:0]  product;
   logic [DIST_W-1:0]  dist_raw;

   assign product  = PROD_W'(echo_width_us) * PROD_W'(speed_q16);
   assign dist_raw = product[DIST_SHIFT +: DIST_W];

   // Depth goes negative when the echo runs past the pipe; its signed width holds the full range.
   assign distance_q10 = measure ? dist_raw : '0;
   assign depth_q10    = measure ? signed'(DEPTH_W'(pipe_length_q10) - DEPTH_W'(dist_raw)) : '0;

endmodule
